[src/cpdu_pkg.sv]
// ----------------------------------------------------------------------------
// cpdu_pkg
// Shared types, codes and helpers for the content pattern hex decoder.
// ----------------------------------------------------------------------------
package cpdu_pkg;

   localparam int CountW     = 13;
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);

   localparam logic [7:0] CharPipe      = 8'h7C;
   localparam logic [7:0] CharBackslash = 8'h5C;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusEmpty   = 2'd1;
   localparam logic [1:0] StatusBadHex  = 2'd2;
   localparam logic [1:0] StatusTrunc   = 2'd3;

   // one queue entry: what a single request leaves for the output side
   typedef struct packed {
      logic              has_byte;
      logic [7:0]        data_byte;
      logic              has_sum;
      logic [CountW-1:0] byte_count;
      logic [1:0]        status;
   } entry_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = 4'(c - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

[src/cpdu_front.sv]
// ----------------------------------------------------------------------------
// cpdu_front
// Per-character parser: tracks literal/hex mode, byte count and errors, and
// pushes one queue entry for each request that yields a byte or a summary.
// ----------------------------------------------------------------------------
module cpdu_front #(
   parameter int MAX_LEN = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_in,
   input  logic                end_of_text,
   output logic                push,
   output cpdu_pkg::entry_type push_entry
);

   localparam int CntW = $clog2(MAX_LEN + 1);

   typedef enum logic [1:0] {
      MODE_LIT,
      MODE_HI,
      MODE_LO,
      MODE_SEP
   } mode_type;

   mode_type        mode_ff, mode_in;
   logic            bs_ff, bs_in;
   logic [3:0]      nib_ff, nib_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            err_ff, err_in;

   cpdu_pkg::hex_type hex;
   logic              want_byte;
   logic              emit;
   logic [7:0]        byte_val;
   logic [1:0]        status;
   logic [CntW+cpdu_pkg::CountW-1:0] cnt_ext;

   assign hex = cpdu_pkg::hex_decode(char_in);

   always_comb begin
      mode_in   = mode_ff;
      bs_in     = bs_ff;
      nib_in    = nib_ff;
      err_in    = err_ff;
      want_byte = 1'b0;
      byte_val  = char_in;
      case (mode_ff)
         MODE_LIT: begin
            if (char_in == cpdu_pkg::CharPipe && !bs_ff) begin
               mode_in = MODE_HI;
               bs_in   = 1'b0;
            end else begin
               want_byte = 1'b1;
               bs_in     = (char_in == cpdu_pkg::CharBackslash);
            end
         end
         MODE_HI: begin
            if (!hex.ok) err_in = 1'b1;
            nib_in  = hex.value;
            mode_in = MODE_LO;
         end
         MODE_LO: begin
            if (!hex.ok) err_in = 1'b1;
            want_byte = 1'b1;
            byte_val  = {nib_ff, hex.value};
            mode_in   = MODE_SEP;
         end
         MODE_SEP: begin
            mode_in = (char_in == cpdu_pkg::CharPipe) ? MODE_LIT : MODE_HI;
            bs_in   = 1'b0;
         end
         default: begin
            mode_in = MODE_LIT;
         end
      endcase

      // saturated count drops further bytes
      emit   = want_byte && (cnt_ff != CntW'(MAX_LEN));
      cnt_in = cnt_ff + CntW'(emit);

      if (err_in) begin
         status = cpdu_pkg::StatusBadHex;
      end else if (mode_in == MODE_HI || mode_in == MODE_LO) begin
         status = cpdu_pkg::StatusTrunc;
      end else if (cnt_in == '0) begin
         status = cpdu_pkg::StatusEmpty;
      end else begin
         status = cpdu_pkg::StatusOk;
      end
   end

   assign cnt_ext = {{cpdu_pkg::CountW{1'b0}}, cnt_in};

   assign push                  = accept && (emit || end_of_text);
   assign push_entry.has_byte   = emit;
   assign push_entry.data_byte  = byte_val;
   assign push_entry.has_sum    = end_of_text;
   assign push_entry.byte_count = cnt_ext[cpdu_pkg::CountW-1:0];
   assign push_entry.status     = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LIT;
         bs_ff   <= 1'b0;
         nib_ff  <= 4'd0;
         cnt_ff  <= '0;
         err_ff  <= 1'b0;
      end else if (accept) begin
         if (end_of_text) begin
            mode_ff <= MODE_LIT;
            bs_ff   <= 1'b0;
            nib_ff  <= 4'd0;
            cnt_ff  <= '0;
            err_ff  <= 1'b0;
         end else begin
            mode_ff <= mode_in;
            bs_ff   <= bs_in;
            nib_ff  <= nib_in;
            cnt_ff  <= cnt_in;
            err_ff  <= err_in;
         end
      end
   end

endmodule

[src/cpdu_queue.sv]
// ----------------------------------------------------------------------------
// cpdu_queue
// Small FIFO of parsed entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module cpdu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cpdu_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output cpdu_pkg::entry_type head
);

   cpdu_pkg::entry_type slot_ff [cpdu_pkg::QueueDepth];

   logic [cpdu_pkg::QPtrW-1:0] wr_ff, wr_in;
   logic [cpdu_pkg::QPtrW-1:0] rd_ff, rd_in;
   logic [cpdu_pkg::QPtrW:0]   fill_ff, fill_in;
   logic                       do_push, do_pop;

   assign full      = (fill_ff == (cpdu_pkg::QPtrW+1)'(cpdu_pkg::QueueDepth));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && not_empty;
   assign wr_in   = wr_ff + cpdu_pkg::QPtrW'(do_push);
   assign rd_in   = rd_ff + cpdu_pkg::QPtrW'(do_pop);
   assign fill_in = fill_ff + (cpdu_pkg::QPtrW+1)'(do_push)
                            - (cpdu_pkg::QPtrW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

[src/cpdu_back.sv]
// ----------------------------------------------------------------------------
// cpdu_back
// Output stage: holds one entry and sends its byte, then its summary, if present.
// ----------------------------------------------------------------------------
module cpdu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cpdu_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          data_byte,
   output logic                byte_valid,
   output logic                done_res,
   output logic [12:0]         byte_count,
   output logic [1:0]          status
);

   cpdu_pkg::entry_type ent_ff;
   logic                valid_ff;
   logic                sum_phase_ff;   // byte already sent, summary next

   logic show_byte;
   logic fire;
   logic finish;

   assign show_byte = ent_ff.has_byte && !sum_phase_ff;
   assign fire      = valid_ff && out_ready;
   assign finish    = fire && !(show_byte && ent_ff.has_sum);
   assign q_pop     = q_valid && (!valid_ff || finish);

   assign out_valid  = valid_ff;
   assign data_byte  = show_byte ? ent_ff.data_byte : 8'd0;
   assign byte_valid = show_byte;
   assign done_res   = !show_byte;
   assign byte_count = show_byte ? 13'd0 : ent_ff.byte_count;
   assign status     = show_byte ? cpdu_pkg::StatusOk : ent_ff.status;

   always_ff @(posedge clock) begin
      if (q_pop) ent_ff <= q_head;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         sum_phase_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            valid_ff     <= 1'b1;
            sum_phase_ff <= 1'b0;
         end else if (finish) begin
            valid_ff     <= 1'b0;
            sum_phase_ff <= 1'b0;
         end else if (fire) begin
            sum_phase_ff <= 1'b1;
         end
      end
   end

endmodule

[src/content_pattern_hex_decoder_unit.sv]
// ----------------------------------------------------------------------------
// content_pattern_hex_decoder_unit
// Decodes a hex-escaped content pattern into raw bytes plus a run summary.
// ----------------------------------------------------------------------------
// The unit takes one pattern character per cycle unless the queue is full
// (req_tready low): the parser decides each character in the cycle it is
// accepted and drops the outcome into a four-entry queue. A request yields
// a byte response, a summary response (tlast high) when it carries tlast,
// both, or nothing. The output port sends one response per cycle while
// rsp_tready is high; the queue absorbs the extra response of a request with
// both. Responses are registered in the queue, then in the output stage.
module content_pattern_hex_decoder_unit #(
   parameter int MAX_LEN = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_byte, [20:8] byte_count,
                                    // [22:21] status, [23] zero
   output logic        rsp_tuser,   // [0] byte_valid
   output logic        rsp_tlast    // done_res
);

   logic                accept;
   logic                push;
   cpdu_pkg::entry_type push_entry;
   logic                q_full;
   logic                q_valid;
   logic                q_pop;
   cpdu_pkg::entry_type q_head;
   logic [7:0]          data_byte;
   logic [12:0]         byte_count;
   logic [1:0]          status;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   cpdu_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_in     (req_tdata),
      .end_of_text (req_tlast),
      .push        (push),
      .push_entry  (push_entry)
   );

   cpdu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   cpdu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .data_byte  (data_byte),
      .byte_valid (rsp_tuser),
      .done_res   (rsp_tlast),
      .byte_count (byte_count),
      .status     (status)
   );

   assign rsp_tdata = {1'b0, status, byte_count, data_byte};

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the content pattern hex decoder. Patterns are fed
// one character per request, literal text and hex regions mixed with broken
// and random input; every response is checked against an in-bench decoder.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxLen     = 4096;
   localparam int RandChars  = 870;

   typedef enum logic [1:0] {
      ModeLiteral,
      ModeHigh,
      ModeLow,
      ModeSeparator
   } parse_mode_type;

   typedef struct packed {
      logic [7:0]                  data_byte;
      logic                        byte_valid;
      logic                        done_res;
      logic [cpdu_pkg::CountW-1:0] byte_count;
      logic [1:0]                  status;
   } decoded_type;

   typedef logic [7:0] text_type[$];

   // decodes the accepted character stream and holds the responses still owed
   class pattern_scoreboard_type;
      parse_mode_type    mode;
      bit                after_bs;
      logic [3:0]        high_nib;
      int unsigned       byte_total;
      bit                saw_bad_digit;
      decoded_type       owed_q[$];
      int unsigned       mismatches;

      function new();
         clear_run();
         mismatches = 0;
      endfunction

      function void clear_run();
         mode          = ModeLiteral;
         after_bs      = 1'b0;
         high_nib      = 4'd0;
         byte_total    = 0;
         saw_bad_digit = 1'b0;
      endfunction

      // {ok, value}; anything that is not a hex digit reads as zero
      function logic [4:0] digit_value(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
         if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
         if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
         return 5'd0;
      endfunction

      function void emit_byte(logic [7:0] b);
         decoded_type r;
         if (byte_total >= MaxLen) return;   // saturated: byte is dropped
         byte_total++;
         r            = '0;
         r.data_byte  = b;
         r.byte_valid = 1'b1;
         owed_q.push_back(r);
      endfunction

      function void note_char(logic [7:0] c, logic last);
         logic [4:0]  h;
         decoded_type s;
         case (mode)
            ModeLiteral: begin
               if (c == cpdu_pkg::CharPipe && !after_bs) begin
                  mode = ModeHigh;
               end else begin
                  emit_byte(c);
                  after_bs = (c == cpdu_pkg::CharBackslash);
               end
            end
            ModeHigh: begin
               h = digit_value(c);
               if (!h[4]) saw_bad_digit = 1'b1;
               high_nib = h[3:0];
               mode     = ModeLow;
            end
            ModeLow: begin
               h = digit_value(c);
               if (!h[4]) saw_bad_digit = 1'b1;
               emit_byte({high_nib, h[3:0]});
               mode = ModeSeparator;
            end
            default: begin
               mode     = (c == cpdu_pkg::CharPipe) ? ModeLiteral : ModeHigh;
               after_bs = 1'b0;
            end
         endcase
         if (last) begin
            s            = '0;
            s.done_res   = 1'b1;
            s.byte_count = cpdu_pkg::CountW'(byte_total);
            if (saw_bad_digit) begin
               s.status = cpdu_pkg::StatusBadHex;
            end else if (mode == ModeHigh || mode == ModeLow) begin
               s.status = cpdu_pkg::StatusTrunc;
            end else if (byte_total == 0) begin
               s.status = cpdu_pkg::StatusEmpty;
            end else begin
               s.status = cpdu_pkg::StatusOk;
            end
            owed_q.push_back(s);
            clear_run();
         end
      endfunction

      function void check_response(logic [23:0] tdata, logic tuser, logic tlast);
         decoded_type got, want;
         got.data_byte  = tdata[7:0];
         got.byte_count = tdata[20:8];
         got.status     = tdata[22:21];
         got.byte_valid = tuser;
         got.done_res   = tlast;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected data=%h valid=%b done=%b count=%0d st=%0d",
                        $realtime, got.data_byte, got.byte_valid, got.done_res,
                        got.byte_count, got.status);
            return;
         end
         want = owed_q.pop_front();
         if (got !== want || tdata[23] !== 1'b0) begin
            mismatches++;
            // data/valid/done/count/status
            if (mismatches <= 10)
               $display("%0t: exp %h/%b/%b/%0d/%0d got %h/%b/%b/%0d/%0d pad=%b",
                        $realtime, want.data_byte, want.byte_valid, want.done_res,
                        want.byte_count, want.status, got.data_byte, got.byte_valid,
                        got.done_res, got.byte_count, got.status, tdata[23]);
         end
      endfunction

      function void check_drained();
         if (owed_q.size() != 0) begin
            mismatches += owed_q.size();
            $display("%0d responses never arrived", owed_q.size());
         end
      endfunction

      function int owed();
         return owed_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] char_in
   logic        req_tlast;    // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [7:0] data_byte, [20:8] byte_count, [22:21] status
   logic        rsp_tuser;    // [0] byte_valid
   logic        rsp_tlast;    // done_res

   int                     send_gap_max;
   int                     recv_gap_max;
   pattern_scoreboard_type board;

   string directed_texts[8] = '{"\\|", "|fF|", "|0g", "|4", "|41 4", "|7a", "||", "|"};

   content_pattern_hex_decoder_unit #(
      .MAX_LEN(MaxLen)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // hex digit of random case, now and then a non-digit
   function automatic logic [7:0] hex_char();
      if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
         0:       return 8'(8'h30 + $urandom_range(0, 9));
         1:       return 8'(8'h61 + $urandom_range(0, 5));
         default: return 8'(8'h41 + $urandom_range(0, 5));
      endcase
   endfunction

   // called just after a falling edge; returns just after the one that follows the accept
   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_char(c, last);
      @(negedge clock);
   endtask

   task automatic send_text(input text_type t);
      foreach (t[i]) send_char(t[i], i == t.size() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.owed() != 0) @(negedge clock);
   endtask

   // mostly well-formed text and hex regions, some random noise
   task automatic make_pattern(output text_type pat);
      int         segs;
      int         n;
      logic [7:0] c;
      pat = {};
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 10);
         repeat (n) pat.push_back(8'($urandom_range(0, 255)));
         return;
      end
      segs = $urandom_range(1, 4);
      for (int s = 0; s < segs; s++) begin
         if ($urandom_range(0, 1) == 1) begin
            n = $urandom_range(1, 5);
            repeat (n) begin
               c = 8'($urandom_range(0, 255));
               if (c == cpdu_pkg::CharPipe || $urandom_range(0, 7) == 0) begin
                  pat.push_back(cpdu_pkg::CharBackslash);
                  if ($urandom_range(0, 1) == 1) c = cpdu_pkg::CharPipe;
               end
               pat.push_back(c);
            end
         end else begin
            pat.push_back(cpdu_pkg::CharPipe);
            n = $urandom_range(1, 4);
            for (int p = 0; p < n; p++) begin
               if (p > 0) begin
                  c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h20;
                  pat.push_back(c == cpdu_pkg::CharPipe ? 8'h20 : c);
               end
               pat.push_back(hex_char());
               pat.push_back(hex_char());
            end
            case ($urandom_range(0, 7))
               0: ;                                  // region left open
               1: begin                              // half a pair
                  pat.push_back(8'h20);
                  pat.push_back(hex_char());
               end
               default: pat.push_back(cpdu_pkg::CharPipe);
            endcase
         end
      end
   endtask

   initial begin
      text_type    pat;
      int unsigned sent;
      req_tvalid   = 1'b0;
      req_tdata    = 8'd0;
      req_tlast    = 1'b0;
      reset        = 1'b1;
      send_gap_max = 13;
      recv_gap_max = 13;
      board        = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      foreach (directed_texts[k]) begin
         pat = {};
         for (int i = 0; i < directed_texts[k].len(); i++)
            pat.push_back(8'(directed_texts[k][i]));
         send_text(pat);
      end
      wait_drained();

      sent = 0;
      while (sent < RandChars) begin
         send_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 13;
         recv_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 13;
         make_pattern(pat);
         send_text(pat);
         sent += pat.size();
         if ($urandom_range(0, 24) == 0) wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      board.check_drained();
      if (board.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = $urandom_range(0, recv_gap_max);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         board.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
         @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
